// ===== rtl/u2u_pkg.sv =====
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the result status codes, the result record and the decoder output record.
// No dependencies.
package u2u_pkg;

  localparam int unsigned RESULT_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_UNIT    = 2'd0,
    ST_INVALID = 2'd1,
    ST_PARTIAL = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] unit_word;
    logic [20:0] code_point;
    status_e     status;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } decode_t;

endpackage

// ===== rtl/u2u_decoder.sv =====
// Per-byte UTF-8 decoder with the open-sequence state registers.
// Produces zero, one or two UTF-16 results for each byte it consumes.
// Depends on u2u_pkg.
module u2u_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              eod_i,
  output u2u_pkg::decode_t  dec_o
);

  typedef struct packed {
    logic              emit;
    u2u_pkg::result_t  res;
    logic              open;
    logic [1:0]        cont;
    logic [4:0]        bits;
  } start_t;

  logic [1:0]  pend_q, pend_d;
  logic [20:0] part_q, part_d;

  function automatic u2u_pkg::result_t make_res(input logic [15:0] unit_word,
                                                input logic [20:0] code_point,
                                                input u2u_pkg::status_e status);
    u2u_pkg::result_t r;
    r.unit_word   = unit_word;
    r.code_point  = code_point;
    r.status      = status;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic start_t start_byte(input logic [7:0] b, input logic eod);
    start_t s;
    s = '0;
    if (!b[7]) begin
      s.emit = 1'b1;
      s.res  = make_res({8'h00, b}, {13'h0000, b}, u2u_pkg::ST_UNIT);
    end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
      s.emit = 1'b1;
      s.res  = make_res(16'h0000, 21'h000000, u2u_pkg::ST_INVALID);
    end else begin
      if (!b[5]) begin
        s.cont = 2'd1;
        s.bits = b[4:0];
      end else if (!b[4]) begin
        s.cont = 2'd2;
        s.bits = {1'b0, b[3:0]};
      end else begin
        s.cont = 2'd3;
        s.bits = {2'b00, b[2:0]};
      end
      if (eod) begin
        s.emit = 1'b1;
        s.res  = make_res(16'h0000, 21'h000000, u2u_pkg::ST_PARTIAL);
      end else begin
        s.open = 1'b1;
      end
    end
    return s;
  endfunction

  start_t            st;
  logic [20:0]       pv;
  logic [20:0]       off;
  logic              bad_cp;
  u2u_pkg::decode_t  dec;

  always_comb begin
    st     = start_byte(byte_i, eod_i);
    pv     = {part_q[14:0], byte_i[5:0]};
    off    = pv - 21'h010000;
    bad_cp = (pv[20:11] == 10'h01B) || (pv[20:16] > 5'h10);
    dec    = '0;
    pend_d = pend_q;
    part_d = part_q;
    if (pend_q == 2'd0) begin
      dec.count = {1'b0, st.emit};
      dec.first = st.res;
      pend_d    = st.open ? st.cont : 2'd0;
      part_d    = st.open ? {16'h0000, st.bits} : 21'h000000;
    end else if (eod_i && pend_q > 2'd1) begin
      dec.count = 2'd1;
      dec.first = make_res(16'h0000, 21'h000000, u2u_pkg::ST_PARTIAL);
      pend_d    = 2'd0;
      part_d    = 21'h000000;
    end else if (byte_i[7:6] != 2'b10) begin
      dec.count  = st.emit ? 2'd2 : 2'd1;
      dec.first  = make_res(16'h0000, 21'h000000, u2u_pkg::ST_INVALID);
      dec.second = st.res;
      pend_d     = st.open ? st.cont : 2'd0;
      part_d     = st.open ? {16'h0000, st.bits} : 21'h000000;
    end else if (pend_q != 2'd1) begin
      pend_d = pend_q - 2'd1;
      part_d = pv;
    end else begin
      pend_d = 2'd0;
      part_d = 21'h000000;
      if (bad_cp) begin
        dec.count = 2'd1;
        dec.first = make_res(16'h0000, 21'h000000, u2u_pkg::ST_INVALID);
      end else if (pv[20:16] == 5'h00) begin
        dec.count = 2'd1;
        dec.first = make_res(pv[15:0], pv, u2u_pkg::ST_UNIT);
      end else begin
        dec.count  = 2'd2;
        dec.first  = make_res({6'b110110, off[19:10]}, pv, u2u_pkg::ST_UNIT);
        dec.second = make_res({6'b110111, off[9:0]}, pv, u2u_pkg::ST_UNIT);
      end
    end
    if (dec.count == 2'd1) begin
      dec.first.last_of_run = 1'b1;
    end
    if (dec.count == 2'd2) begin
      dec.second.last_of_run = 1'b1;
    end
    dec_o = dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= 21'h000000;
    end else if (fire_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

// ===== rtl/u2u_result_fifo.sv =====
// Result queue that takes up to two results per cycle and hands out one per beat.
// Reports space while at least two entries are free.
// Depends on u2u_pkg.
module u2u_result_fifo #(
  parameter int unsigned Depth = u2u_pkg::RESULT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u2u_pkg::decode_t  dec_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u2u_pkg::result_t  head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, wnext, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       npush;
  logic             pop;

  function automatic logic [PtrW-1:0] incr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    npush  = push_i ? dec_i.count : 2'd0;
    pop    = out_valid_o && out_ready_i;
    wnext  = incr(wptr_q);
    wptr_d = wptr_q;
    if (npush == 2'd1) begin
      wptr_d = wnext;
    end else if (npush == 2'd2) begin
      wptr_d = incr(wnext);
    end
    rptr_d = pop ? incr(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(npush) - CntW'(pop);
  end

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rptr_q];
  assign space_o     = (cnt_q <= CntW'(Depth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      mem_q[wptr_q] <= dec_i.first;
    end
    if (npush == 2'd2) begin
      mem_q[wnext] <= dec_i.second;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder: input register, per-byte decoder and a result queue.
// An input beat passes through the input register and the decoder into the result queue, which drives the output.
// Throughput is one byte per cycle while the queue has space; a surrogate pair or an error followed by a
// restart puts two results on the output, one per cycle while out_ready_i is high, set by the single output port.
// Reset clears the open sequence, the input register's valid flag and the queue.
// Depends on u2u_pkg, u2u_decoder and u2u_result_fifo.
module utf8_to_utf16_transcoder #(
  parameter int unsigned ResultDepth = u2u_pkg::RESULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] unit_word_o,
  output logic [20:0] code_point_o,
  output logic [1:0]  status_o,
  output logic        last_of_run_o
);

  logic              valid_q;
  logic [7:0]        byte_q;
  logic              eod_q;
  logic              space;
  logic              fire;
  u2u_pkg::decode_t  dec;
  u2u_pkg::result_t  head;

  assign fire       = valid_q && space;
  assign in_ready_o = !valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_value_i;
      eod_q  <= end_of_data_i;
    end
  end

  u2u_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .eod_i  (eod_q),
    .dec_o  (dec)
  );

  u2u_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .dec_i       (dec),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign unit_word_o   = head.unit_word;
  assign code_point_o  = head.code_point;
  assign status_o      = head.status;
  assign last_of_run_o = head.last_of_run;

endmodule

// ===== rtl/u2u_checker.sv =====
// Port-level checker for the UTF-8 to UTF-16 transcoder, bound to the top level.
// Depends on u2u_pkg.
module u2u_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] unit_word_o,
  input logic [20:0] code_point_o,
  input logic [1:0]  status_o,
  input logic        last_of_run_o
);

  // A stalled result beat keeps its unit, status and last-of-run flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(unit_word_o) &&
      $stable(status_o) && $stable(last_of_run_o))
    else $error("stalled result beat changed");

  // Error results carry no unit and no code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != u2u_pkg::ST_UNIT |-> unit_word_o == 16'h0000 &&
      code_point_o == 21'h000000)
    else $error("error result carries data");

  // A high surrogate is never the last result of its byte and carries a code point above 16'hFFFF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == u2u_pkg::ST_UNIT && unit_word_o[15:10] == 6'b110110
      |-> !last_of_run_o && code_point_o[20:16] != 5'h00)
    else $error("high surrogate marked last");

  // A low surrogate always ends the run of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == u2u_pkg::ST_UNIT && unit_word_o[15:10] == 6'b110111
      |-> last_of_run_o)
    else $error("low surrogate not marked last");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_checker (.*);
